FILE: rtl/core/fed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fed_pkg;

   // sample squares and sums
   localparam int AXIS_COUNT   = 6;
   localparam int ACCEL_AXES   = 3;
   localparam int AXIS_INDEX_W = 3;
   localparam int SAMPLE_W     = 16;
   localparam int SQUARE_W     = 31;
   localparam int SUM_W        = 32;

   // bit-serial root
   localparam int ROOT_W      = 16;
   localparam int ROOT_STEP_W = 4;

   // moving average weight, about 0.35 in q16
   localparam int                 ALPHA_W     = 15;
   localparam logic [ALPHA_W-1:0] ALPHA_Q16   = 15'd22938;
   localparam int                 ALPHA_SHIFT = 16;
   localparam logic [15:0]        ROUND_UP    = 16'hFFFF;

   localparam logic [15:0] MAG_ONE_G = 16'd16384;

   // register file
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CFG_FREE_FALL_LEVEL  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_FREE_FALL_MIN_MS = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_IMPACT_WINDOW_MS = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CFG_IMPACT_LEVEL     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CFG_JERK_LEVEL       = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CFG_ROTATION_LEVEL   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CFG_JERK_REARM_MS    = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CFG_IMPACT_REARM_MS  = 4'd7;

   localparam logic [CSR_DATA_W-1:0] FREE_FALL_LEVEL_RST  = 16'd9830;
   localparam logic [CSR_DATA_W-1:0] FREE_FALL_MIN_MS_RST = 16'd60;
   localparam logic [CSR_DATA_W-1:0] IMPACT_WINDOW_MS_RST = 16'd300;
   localparam logic [CSR_DATA_W-1:0] IMPACT_LEVEL_RST     = 16'd26214;
   localparam logic [CSR_DATA_W-1:0] JERK_LEVEL_RST       = 16'd9830;
   localparam logic [CSR_DATA_W-1:0] ROTATION_LEVEL_RST   = 16'd26200;
   localparam logic [CSR_DATA_W-1:0] JERK_REARM_MS_RST    = 16'd150;
   localparam logic [CSR_DATA_W-1:0] IMPACT_REARM_MS_RST  = 16'd200;

   typedef enum logic [1:0] {
      PHASE_IDLE         = 2'd0,
      PHASE_FREE_FALL    = 2'd1,
      PHASE_AWAIT_IMPACT = 2'd2,
      PHASE_HOLDOFF      = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ALERT_NONE     = 2'd0,
      ALERT_JERK_ROT = 2'd1,
      ALERT_IMPACT   = 2'd2
   } alert_type;

   typedef struct packed {
      logic                    capture;
      logic                    square;
      logic [AXIS_INDEX_W-1:0] axis;
      logic                    root_start;
      logic                    diff;
      logic                    mul;
      logic                    avg;
      logic                    decide;
   } dp_cmd_type;

   typedef struct packed {
      logic root_busy;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/fed_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fed_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic        [31:0] time_ms;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
                   input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms,
                 output ready);
endinterface

interface fed_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  alert;
   logic [1:0]  phase;
   logic [15:0] accel_magnitude;
   logic [15:0] filtered_magnitude;
   logic [15:0] jerk;
   logic [15:0] rotation_magnitude;

   modport source (output valid, alert, phase, accel_magnitude, filtered_magnitude, jerk,
                   rotation_magnitude, input ready);
   modport sink (input valid, alert, phase, accel_magnitude, filtered_magnitude, jerk,
                 rotation_magnitude, output ready);
endinterface

interface fed_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fed_pkg::CSR_INDEX_W-1:0]    index;
   logic [fed_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fall_event_detector_unit.sv
// Fall event detector.
// req_ch carries one raw accelerometer and gyro sample with its millisecond
// timestamp; rsp_ch returns one result item per sample: alert code, phase
// after the sample, acceleration and rotation magnitudes, filtered magnitude
// and jerk. csr_ch writes the eight 16-bit thresholds and times by index; it
// is always ready and drops indexes past the last register. The user must
// make writes only while no sample is in flight; the block does not enforce it.
// Flow: one 16x16 multiplier squares the six axes in turn, a further step
// finishes the sums, two bit-serial square root units run side by side for
// 16 steps until both are done, the moving average takes difference,
// multiply and update steps, and a decision step sets the phase. A new
// sample is taken only after the previous one has passed its decision step.
// req_ch.ready is high only while no sample is being worked on.
// The result sits in an output register; a stalled receiver does not hold up
// the next sample, which is accepted and computed and then waits in its
// decision step until the previous result has been taken.
// Reset (synchronous, active high) loads the default thresholds, sets the
// phase to idle, the average and last magnitude to one g, and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module fall_event_detector_unit #(
   parameter int FILTER_FRACTION_BITS = 8,
   parameter int TIME_WIDTH           = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   fed_req_if.sink    req_ch,
   fed_rsp_if.source  rsp_ch,
   fed_csr_if.sink    csr_ch
);

   fed_pkg::dp_cmd_type    cmd;
   fed_pkg::dp_status_type status;
   logic                   csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;

   fed_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fed_datapath #(
      .FILTER_FRACTION_BITS (FILTER_FRACTION_BITS),
      .TIME_WIDTH           (TIME_WIDTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .accel_x                (req_ch.accel_x),
      .accel_y                (req_ch.accel_y),
      .accel_z                (req_ch.accel_z),
      .gyro_x                 (req_ch.gyro_x),
      .gyro_y                 (req_ch.gyro_y),
      .gyro_z                 (req_ch.gyro_z),
      .time_ms                (req_ch.time_ms),
      .csr_write              (csr_write),
      .csr_index              (csr_ch.index),
      .csr_data               (csr_ch.data),
      .rsp_alert              (rsp_ch.alert),
      .rsp_phase              (rsp_ch.phase),
      .rsp_accel_magnitude    (rsp_ch.accel_magnitude),
      .rsp_filtered_magnitude (rsp_ch.filtered_magnitude),
      .rsp_jerk               (rsp_ch.jerk),
      .rsp_rotation_magnitude (rsp_ch.rotation_magnitude)
   );

endmodule

`default_nettype wire

FILE: rtl/core/fed_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module fed_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [fed_pkg::SUM_W-1:0]    radicand,
   output logic                              busy,
   output logic [fed_pkg::ROOT_W-1:0]        root
);

   localparam int REM_W   = fed_pkg::ROOT_W + 2;
   localparam int SHIFT_W = REM_W + 2;
   localparam logic [fed_pkg::ROOT_STEP_W-1:0] LAST_STEP =
      fed_pkg::ROOT_STEP_W'(fed_pkg::ROOT_W - 1);

   logic [fed_pkg::SUM_W-1:0]       rad_ff, rad_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [fed_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic [fed_pkg::ROOT_STEP_W-1:0] step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic [SHIFT_W-1:0]              rem_shift, trial, rem_diff;

   // one result bit per cycle, two radicand bits shifted in
   always_comb begin
      rem_shift = {rem_ff, rad_ff[fed_pkg::SUM_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      rem_diff  = rem_shift - trial;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         step_in = step_ff + 1'b1;
         if (rem_shift >= trial) begin
            rem_in  = rem_diff[REM_W-1:0];
            root_in = {root_ff[fed_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[REM_W-1:0];
            root_in = {root_ff[fed_pkg::ROOT_W-2:0], 1'b0};
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("root unit not busy after start");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && step_ff == LAST_STEP |=> !busy_ff)
      else $error("root unit ran past its last step");

endmodule

`default_nettype wire

FILE: rtl/core/fed_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fed_datapath #(
   parameter int FILTER_FRACTION_BITS = 8,
   parameter int TIME_WIDTH           = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fed_pkg::dp_cmd_type                 cmd,
   output fed_pkg::dp_status_type                   status,
   input  wire logic signed [15:0]                  accel_x,
   input  wire logic signed [15:0]                  accel_y,
   input  wire logic signed [15:0]                  accel_z,
   input  wire logic signed [15:0]                  gyro_x,
   input  wire logic signed [15:0]                  gyro_y,
   input  wire logic signed [15:0]                  gyro_z,
   input  wire logic        [31:0]                  time_ms,
   input  wire logic                                csr_write,
   input  wire logic [fed_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fed_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [1:0]                               rsp_alert,
   output logic [1:0]                               rsp_phase,
   output logic [15:0]                              rsp_accel_magnitude,
   output logic [15:0]                              rsp_filtered_magnitude,
   output logic [15:0]                              rsp_jerk,
   output logic [15:0]                              rsp_rotation_magnitude
);

   localparam int F      = FILTER_FRACTION_BITS;
   localparam int AVG_W  = 16 + F;
   localparam int PROD_W = AVG_W + fed_pkg::ALPHA_W;
   localparam logic [AVG_W-1:0] AVG_RST = {fed_pkg::MAG_ONE_G, {F{1'b0}}};

   // configuration
   logic [15:0] free_fall_level_ff, free_fall_min_ms_ff, impact_window_ms_ff, impact_level_ff;
   logic [15:0] jerk_level_ff, rotation_level_ff, jerk_rearm_ms_ff, impact_rearm_ms_ff;

   // captured sample
   logic signed [fed_pkg::SAMPLE_W-1:0] axis_ff [fed_pkg::AXIS_COUNT];
   logic [TIME_WIDTH-1:0]               now_ff;

   // squares and sums
   logic signed [2*fed_pkg::SAMPLE_W-1:0] square_full;
   logic [fed_pkg::SQUARE_W-1:0]          sq_ff;
   logic [fed_pkg::AXIS_INDEX_W-1:0]      sq_idx_ff;
   logic                                  sq_vld_ff;
   logic [fed_pkg::SUM_W-1:0]             accel_sum_ff, accel_sum_in;
   logic [fed_pkg::SUM_W-1:0]             rot_sum_ff, rot_sum_in;

   logic [15:0] mag, rot;
   logic        accel_busy, rot_busy;

   // filter
   logic [AVG_W-1:0]  m_fix, diff_in, diff_ff, avg_next_in, avg_next_ff;
   logic              neg_in, neg_ff;
   logic [PROD_W-1:0] prod_ff;

   // detector state
   fed_pkg::phase_type    phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [15:0]           rearm_ff, rearm_in;
   logic [AVG_W-1:0]      avg_ff;
   logic [15:0]           prev_ff;

   logic [TIME_WIDTH-1:0] elapsed;
   logic                  hold, low, jerk_rot;
   logic [15:0]           jerk, filtered;
   fed_pkg::alert_type    alert_in;

   // result register
   fed_pkg::alert_type rsp_alert_ff;
   fed_pkg::phase_type rsp_phase_ff;
   logic [15:0]        rsp_mag_ff, rsp_filt_ff, rsp_jerk_ff, rsp_rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_fall_level_ff  <= fed_pkg::FREE_FALL_LEVEL_RST;
         free_fall_min_ms_ff <= fed_pkg::FREE_FALL_MIN_MS_RST;
         impact_window_ms_ff <= fed_pkg::IMPACT_WINDOW_MS_RST;
         impact_level_ff     <= fed_pkg::IMPACT_LEVEL_RST;
         jerk_level_ff       <= fed_pkg::JERK_LEVEL_RST;
         rotation_level_ff   <= fed_pkg::ROTATION_LEVEL_RST;
         jerk_rearm_ms_ff    <= fed_pkg::JERK_REARM_MS_RST;
         impact_rearm_ms_ff  <= fed_pkg::IMPACT_REARM_MS_RST;
      end else if (csr_write) begin
         case (csr_index)
            fed_pkg::CFG_FREE_FALL_LEVEL:  free_fall_level_ff  <= csr_data;
            fed_pkg::CFG_FREE_FALL_MIN_MS: free_fall_min_ms_ff <= csr_data;
            fed_pkg::CFG_IMPACT_WINDOW_MS: impact_window_ms_ff <= csr_data;
            fed_pkg::CFG_IMPACT_LEVEL:     impact_level_ff     <= csr_data;
            fed_pkg::CFG_JERK_LEVEL:       jerk_level_ff       <= csr_data;
            fed_pkg::CFG_ROTATION_LEVEL:   rotation_level_ff   <= csr_data;
            fed_pkg::CFG_JERK_REARM_MS:    jerk_rearm_ms_ff    <= csr_data;
            fed_pkg::CFG_IMPACT_REARM_MS:  impact_rearm_ms_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // one shared multiplier squares the six axes in turn
   assign square_full = axis_ff[cmd.axis] * axis_ff[cmd.axis];

   always_comb begin
      accel_sum_in = accel_sum_ff;
      rot_sum_in   = rot_sum_ff;
      if (cmd.capture) begin
         accel_sum_in = '0;
         rot_sum_in   = '0;
      end else if (sq_vld_ff) begin
         if (sq_idx_ff < fed_pkg::AXIS_INDEX_W'(fed_pkg::ACCEL_AXES)) begin
            accel_sum_in = accel_sum_ff + fed_pkg::SUM_W'(sq_ff);
         end else begin
            rot_sum_in = rot_sum_ff + fed_pkg::SUM_W'(sq_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= cmd.square;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         axis_ff[0] <= accel_x;
         axis_ff[1] <= accel_y;
         axis_ff[2] <= accel_z;
         axis_ff[3] <= gyro_x;
         axis_ff[4] <= gyro_y;
         axis_ff[5] <= gyro_z;
         now_ff     <= time_ms[TIME_WIDTH-1:0];
      end
      if (cmd.square) begin
         sq_ff     <= square_full[fed_pkg::SQUARE_W-1:0];
         sq_idx_ff <= cmd.axis;
      end
      accel_sum_ff <= accel_sum_in;
      rot_sum_ff   <= rot_sum_in;
   end

   fed_sqrt u_accel_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (accel_sum_ff),
      .busy     (accel_busy),
      .root     (mag)
   );

   fed_sqrt u_rot_root (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (rot_sum_ff),
      .busy     (rot_busy),
      .root     (rot)
   );

   assign status.root_busy = accel_busy | rot_busy;

   // filter: signed difference, weight multiply, update with floor
   always_comb begin
      m_fix = {mag, {F{1'b0}}};
      if (m_fix >= avg_ff) begin
         diff_in = m_fix - avg_ff;
         neg_in  = 1'b0;
      end else begin
         diff_in = avg_ff - m_fix;
         neg_in  = 1'b1;
      end
      if (neg_ff) begin
         avg_next_in = avg_ff - AVG_W'((prod_ff + PROD_W'(fed_pkg::ROUND_UP))
                                       >> fed_pkg::ALPHA_SHIFT);
      end else begin
         avg_next_in = avg_ff + AVG_W'(prod_ff >> fed_pkg::ALPHA_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff <= diff_in;
         neg_ff  <= neg_in;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(fed_pkg::ALPHA_Q16);
      end
      if (cmd.avg) begin
         avg_next_ff <= avg_next_in;
      end
   end

   // detector decision
   always_comb begin
      elapsed  = now_ff - start_ff;
      hold     = (phase_ff == fed_pkg::PHASE_HOLDOFF) && (elapsed < TIME_WIDTH'(rearm_ff));
      jerk     = (mag >= prev_ff) ? (mag - prev_ff) : (prev_ff - mag);
      low      = avg_next_ff < {free_fall_level_ff, {F{1'b0}}};
      jerk_rot = (jerk > jerk_level_ff) && (rot > rotation_level_ff);
      filtered = hold ? avg_ff[AVG_W-1:F] : avg_next_ff[AVG_W-1:F];
      phase_in = phase_ff;
      start_in = start_ff;
      rearm_in = rearm_ff;
      alert_in = fed_pkg::ALERT_NONE;
      if (!hold) begin
         case (phase_ff)
            fed_pkg::PHASE_IDLE, fed_pkg::PHASE_HOLDOFF: begin
               phase_in = fed_pkg::PHASE_IDLE;
               if (low) begin
                  phase_in = fed_pkg::PHASE_FREE_FALL;
                  start_in = now_ff;
               end else if (jerk_rot) begin
                  alert_in = fed_pkg::ALERT_JERK_ROT;
                  phase_in = fed_pkg::PHASE_HOLDOFF;
                  start_in = now_ff;
                  rearm_in = jerk_rearm_ms_ff;
               end
            end
            fed_pkg::PHASE_FREE_FALL: begin
               if (!low) begin
                  phase_in = fed_pkg::PHASE_IDLE;
               end else if (elapsed >= TIME_WIDTH'(free_fall_min_ms_ff)) begin
                  phase_in = fed_pkg::PHASE_AWAIT_IMPACT;
                  start_in = now_ff;
               end
            end
            fed_pkg::PHASE_AWAIT_IMPACT: begin
               if (mag > impact_level_ff || jerk_rot) begin
                  alert_in = fed_pkg::ALERT_IMPACT;
                  phase_in = fed_pkg::PHASE_HOLDOFF;
                  start_in = now_ff;
                  rearm_in = impact_rearm_ms_ff;
               end else if (elapsed > TIME_WIDTH'(impact_window_ms_ff)) begin
                  phase_in = fed_pkg::PHASE_IDLE;
               end
            end
            default: phase_in = fed_pkg::PHASE_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fed_pkg::PHASE_IDLE;
         start_ff <= '0;
         rearm_ff <= '0;
         avg_ff   <= AVG_RST;
         prev_ff  <= fed_pkg::MAG_ONE_G;
      end else if (cmd.decide) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         rearm_ff <= rearm_in;
         // an ignored sample leaves the filter and last magnitude alone
         if (!hold) begin
            avg_ff  <= avg_next_ff;
            prev_ff <= mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_alert_ff <= alert_in;
         rsp_phase_ff <= phase_in;
         rsp_mag_ff   <= mag;
         rsp_filt_ff  <= filtered;
         rsp_jerk_ff  <= jerk;
         rsp_rot_ff   <= rot;
      end
   end

   assign rsp_alert              = rsp_alert_ff;
   assign rsp_phase              = rsp_phase_ff;
   assign rsp_accel_magnitude    = rsp_mag_ff;
   assign rsp_filtered_magnitude = rsp_filt_ff;
   assign rsp_jerk               = rsp_jerk_ff;
   assign rsp_rotation_magnitude = rsp_rot_ff;

   a_alert_enters_holdoff: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> (rsp_alert_ff == fed_pkg::ALERT_NONE ||
                      phase_ff == fed_pkg::PHASE_HOLDOFF))
      else $error("alert reported without entering holdoff");

endmodule

`default_nettype wire

FILE: rtl/core/fed_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module fed_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire fed_pkg::dp_status_type status,
   output fed_pkg::dp_cmd_type         cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_SQUARE    = 9'b000000010,
      S_SUM       = 9'b000000100,
      S_ROOT_GO   = 9'b000001000,
      S_ROOT_WAIT = 9'b000010000,
      S_DIFF      = 9'b000100000,
      S_MUL       = 9'b001000000,
      S_AVG       = 9'b010000000,
      S_DECIDE    = 9'b100000000
   } ctrl_state_type;

   localparam logic [fed_pkg::AXIS_INDEX_W-1:0] LAST_AXIS =
      fed_pkg::AXIS_INDEX_W'(fed_pkg::AXIS_COUNT - 1);

   ctrl_state_type                   state_ff, state_in;
   logic [fed_pkg::AXIS_INDEX_W-1:0] axis_ff, axis_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.axis = axis_ff;
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               axis_in     = '0;
               state_in    = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            if (axis_ff == LAST_AXIS) begin
               state_in = S_SUM;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         // last square lands in its sum
         S_SUM: state_in = S_ROOT_GO;
         S_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (!status.root_busy) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_AVG;
         end
         S_AVG: begin
            cmd.avg  = 1'b1;
            state_in = S_DECIDE;
         end
         // wait here while the previous result is still unclaimed
         S_DECIDE: begin
            if (out_free) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_capture_starts_squares: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_SQUARE && axis_ff == '0))
      else $error("item capture did not start the square sequence");

   a_roots_then_filter: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROOT_WAIT && !status.root_busy |=> cmd.diff)
      else $error("filter did not follow the finished roots");

   a_decide_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_valid_ff)
      else $error("result not offered after decision");

endmodule

`default_nettype wire
